/* rtl/mct_pkg.sv */
// Shared constants, codes and types for the Toffoli cascade evaluator.
`timescale 1ns / 1ps

package mct_pkg;

  // Fixed field widths of the request and result channels.
  localparam int MAX_WIRES  = 10;
  localparam int VEC_W      = 10;
  localparam int CODE_W     = 2 * MAX_WIRES;
  localparam int WIRE_W     = 4;
  localparam int GCNT_W     = 9;
  localparam int IDX_W      = 8;
  localparam int MCNT_W     = 16;
  localparam int CFG_DATA_W = 9;

  typedef logic [VEC_W-1:0]  vec_t;
  typedef logic [CODE_W-1:0] codes_t;
  typedef logic [WIRE_W-1:0] wires_t;
  typedef logic [MCNT_W-1:0] mcount_t;

  // Per-wire gate codes.
  typedef logic [1:0] gate_code_t;
  localparam gate_code_t CODE_ZERO   = 2'd0;
  localparam gate_code_t CODE_ONE    = 2'd1;
  localparam gate_code_t CODE_NONE   = 2'd2;
  localparam gate_code_t CODE_TARGET = 2'd3;

  // Request kinds.
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } action_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_WIRE_COUNT = 1'b0,
    CFG_GATE_COUNT = 1'b1
  } cfg_idx_t;

  localparam wires_t          WIRE_COUNT_RST = 4'd6;
  localparam logic [GCNT_W-1:0] GATE_COUNT_RST = 9'd4;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

endpackage

/* rtl/mct_req_if.sv */
// Request channel: valid/ready handshake carrying one write or evaluate request.
`timescale 1ns / 1ps

interface mct_req_if;
  import mct_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 action;
  logic                 first_of_set;
  logic [IDX_W-1:0]     gate_index;
  logic [CODE_W-1:0]    gate_codes;
  logic [VEC_W-1:0]     input_vector;
  logic [VEC_W-1:0]     expected_vector;

  modport source (
    output valid, action, first_of_set, gate_index, gate_codes, input_vector,
           expected_vector,
    input  ready
  );

  modport sink (
    input  valid, action, first_of_set, gate_index, gate_codes, input_vector,
           expected_vector,
    output ready
  );
endinterface

/* rtl/mct_res_if.sv */
// Result channel: valid/ready handshake carrying one result per request.
`timescale 1ns / 1ps

interface mct_res_if;
  import mct_pkg::*;

  logic              valid;
  logic              ready;
  logic [VEC_W-1:0]  result_vector;
  logic              matched;
  logic [MCNT_W-1:0] match_count;

  modport source (
    output valid, result_vector, matched, match_count,
    input  ready
  );

  modport sink (
    input  valid, result_vector, matched, match_count,
    output ready
  );
endinterface

/* rtl/mct_gate_unit.sv */
// Applies one mixed-polarity multiple-control Toffoli gate to a wire vector.
`timescale 1ns / 1ps

module mct_gate_unit (
  input  mct_pkg::wires_t wires,
  input  mct_pkg::vec_t   vec_in,
  input  mct_pkg::codes_t codes,
  output mct_pkg::vec_t   vec_out
);
  import mct_pkg::*;

  logic        fire;
  logic        has_tgt;
  wires_t      tgt_pos;
  wires_t      pos;
  gate_code_t  code;

  // Scan the wires in parallel: controls must all match, the target on the highest-numbered wire wins.
  // Wire 0 sits at the most significant of the active bits.
  always_comb begin
    fire    = 1'b1;
    has_tgt = 1'b0;
    tgt_pos = '0;
    pos     = '0;
    code    = CODE_NONE;
    for (int j = 0; j < MAX_WIRES; j++) begin
      if (WIRE_W'(j) < wires) begin
        pos  = wires - WIRE_W'(1) - WIRE_W'(j);
        code = codes[2*j +: 2];
        if (code == CODE_TARGET) begin
          has_tgt = 1'b1;
          tgt_pos = pos;
        end else if (code != CODE_NONE && code != {1'b0, vec_in[pos]}) begin
          fire = 1'b0;
        end
      end
    end
  end

  // Flip the target bit when the gate fires.
  assign vec_out = (fire && has_tgt) ? (vec_in ^ (VEC_W'(1) << tgt_pos)) : vec_in;

endmodule

/* rtl/mct_cascade_evaluator.sv */
// Top level: gate store, cascade sequencer, match counter and result register.
// An evaluate request walks the gate store one gate per cycle through a registered read
// port, applying G gates (G = gate_count capped at MAX_GATES); a write request stores
// one gate's codes instead. A new request is taken only in idle, and a result the sink has
// not taken holds back the next commit. Synchronous reset (rst_n low) clears the sequencer,
// match counter and result valid, and sets wire_count to 6 and gate_count to 4.
`timescale 1ns / 1ps

module mct_cascade_evaluator #(
  parameter int MAX_GATES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  mct_pkg::cfg_idx_t               cfg_index,
  input  logic [mct_pkg::CFG_DATA_W-1:0]  cfg_data,
  mct_req_if.sink                         in_chan,
  mct_res_if.source                       out_chan
);
  import mct_pkg::*;

  localparam int ADDR_W = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
  localparam int CNT_W  = $clog2(MAX_GATES + 1);
  localparam int CMP_W  = (CNT_W > GCNT_W) ? CNT_W : GCNT_W;

  // Configuration registers.
  wires_t              wire_count_r;
  logic [GCNT_W-1:0]   gate_count_r;

  // Sequencer and datapath registers.
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    issue_cnt_r;
  logic [CNT_W-1:0]    gates_r;
  wires_t              wires_r;
  vec_t                vec_r;
  vec_t                expected_r;
  logic                first_r;
  logic                is_eval_r;
  mcount_t             count_r;

  // Result register.
  logic                out_valid_r;
  vec_t                out_vec_r;
  logic                out_matched_r;
  mcount_t             out_count_r;

  // Gate store.
  codes_t              gate_mem [MAX_GATES];
  codes_t              rd_data_r;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                mem_we;

  logic                in_ready;
  logic                accept;
  logic                acc_eval;
  logic                commit;
  wires_t              wires_lim;
  logic [CNT_W-1:0]    gates_lim;
  vec_t                in_mask;
  vec_t                vec_step;
  logic                hit;
  logic                clear_cnt;
  mcount_t             count_base;
  mcount_t             count_nxt;

  // Request acceptance and limits of the current configuration.
  assign accept    = in_chan.valid && in_ready;
  assign acc_eval  = (in_chan.action == ACT_EVAL);
  assign wires_lim = (wire_count_r > WIRE_W'(MAX_WIRES)) ? WIRE_W'(MAX_WIRES) : wire_count_r;
  assign gates_lim = (CMP_W'(gate_count_r) > CMP_W'(MAX_GATES)) ? CNT_W'(MAX_GATES)
                                                                 : CNT_W'(gate_count_r);
  assign in_mask   = VEC_W'((32'd1 << wires_lim) - 32'd1);
  assign mem_we    = accept && !acc_eval && (32'(in_chan.gate_index) < 32'(MAX_GATES));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wire_count_r <= WIRE_COUNT_RST;
      gate_count_r <= GATE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIRE_COUNT: wire_count_r <= cfg_data[WIRE_W-1:0];
        CFG_GATE_COUNT: gate_count_r <= cfg_data[GCNT_W-1:0];
        default:        ;
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (acc_eval && gates_lim != '0) ? ST_RUN : ST_FINISH;
        end
      end
      ST_RUN: begin
        if (issue_cnt_r == gates_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: request ready, store reads and result commit.
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    commit   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_chan.valid && acc_eval;
      end
      ST_RUN: begin
        rd_en   = (issue_cnt_r != gates_r);
        rd_addr = issue_cnt_r[ADDR_W-1:0];
      end
      ST_FINISH: begin
        commit = !out_valid_r || out_chan.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Gate store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      gate_mem[ADDR_W'(in_chan.gate_index)] <= in_chan.gate_codes;
    end
    if (rd_en) begin
      rd_data_r <= gate_mem[rd_addr];
    end
  end

  // One gate applied per cycle while running.
  mct_gate_unit u_gate (
    .wires   (wires_r),
    .vec_in  (vec_r),
    .codes   (rd_data_r),
    .vec_out (vec_step)
  );

  // Working vector and request fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      wires_r     <= wires_lim;
      gates_r     <= gates_lim;
      issue_cnt_r <= CNT_W'(1);
      vec_r       <= in_chan.input_vector & in_mask;
      expected_r  <= in_chan.expected_vector;
      first_r     <= in_chan.first_of_set;
      is_eval_r   <= acc_eval;
    end else if (state_r == ST_RUN) begin
      vec_r <= vec_step;
      if (rd_en) begin
        issue_cnt_r <= issue_cnt_r + CNT_W'(1);
      end
    end
  end

  // Compare and saturating match count.
  assign hit        = is_eval_r && (vec_r == expected_r);
  assign clear_cnt  = is_eval_r && first_r;
  assign count_base = clear_cnt ? '0 : count_r;
  assign count_nxt  = (hit && count_base != '1) ? count_base + MCNT_W'(1) : count_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (commit) begin
      out_vec_r     <= is_eval_r ? vec_r : '0;
      out_matched_r <= hit;
      out_count_r   <= count_nxt;
    end
  end

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.result_vector = out_vec_r;
  assign out_chan.matched       = out_matched_r;
  assign out_chan.match_count   = out_count_r;

  // The issue counter stays within the cascade while running.
  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (issue_cnt_r != '0 && issue_cnt_r <= gates_r))
    else $error("issue counter out of range while running");

  // A reported match always comes with a non-zero count.
  a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.matched) |-> (out_chan.match_count != '0))
    else $error("match reported with zero count");

  // The counter only falls when an evaluation starts a new set.
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !(commit && clear_cnt) |=> (count_r >= $past(count_r)))
    else $error("match counter decreased without a clear");

endmodule
